/* design/piecewise_linear_table_interp_top_assert.svh */
// Assertion macros shared by the piecewise linear table interpolator.
`ifndef PIECEWISE_LINEAR_TABLE_INTERP_TOP_ASSERT_SVH
`define PIECEWISE_LINEAR_TABLE_INTERP_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define PLTI_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
`define PLTI_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define PLTI_ASSERT_IMP(label, clk, rst, ante, cons, msg)
`define PLTI_ASSERT_NXT(label, clk, rst, ante, cons, msg)
`endif
`endif

/* design/plti_pkg.sv */
// Shared types and constants of the piecewise linear table interpolator.
`timescale 1ns / 1ps
`default_nettype none
package plti_pkg;

   localparam int DENS_W = 16;
   localparam int LAC_W  = 32;
   localparam int ENT_W  = DENS_W + LAC_W;
   localparam int PROD_W = DENS_W + LAC_W;
   localparam int DCNT_W = $clog2(LAC_W);

   localparam logic [1:0] ACT_LOOKUP = 2'd0;
   localparam logic [1:0] ACT_APPEND = 2'd1;
   localparam logic [1:0] ACT_CLEAR  = 2'd2;

   localparam logic [1:0] STAT_OK    = 2'd0;
   localparam logic [1:0] STAT_EMPTY = 2'd1;
   localparam logic [1:0] STAT_FULL  = 2'd2;

   typedef struct packed {
      logic start;
   } div_ctl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

endpackage
`default_nettype wire

/* design/piecewise_linear_table_interp_top.sv */
// Top level of the piecewise linear attenuation table interpolator.
// Append, clear, unused and rejected transactions, and a lookup on an empty table, pass from
// acceptance through the dispatch state to the output state. Any other lookup reads the first
// and last breakpoints and then scans the breakpoints one per cycle through the single read
// port of the breakpoint RAM. It clamps to the first or last breakpoint, or it interpolates
// below the first breakpoint that lies above the density, taking the quotient from a divider
// that forms one bit per cycle. req_tready returns in the same cycle that the result reaches
// the output register, so a new transaction can be accepted while the previous result still
// waits in the output register; a result that finds that register occupied waits until it
// is taken.
`timescale 1ns / 1ps
`default_nettype none
`include "piecewise_linear_table_interp_top_assert.svh"
module piecewise_linear_table_interp_top
   import plti_pkg::*;
#(
   parameter int MAX_TABLES  = 4,
   parameter int MAX_ENTRIES = 64
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_wr_en,
   input  wire logic [1:0]  csr_wr_data,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [47:0] req_tdata,  // density[15:0], lac_value[47:16]
   input  wire logic [3:0]  req_tuser,  // action[1:0], table_id[3:2]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic      [31:0] rsp_tdata,  // lac[31:0]
   output logic      [1:0]  rsp_tuser   // status[1:0]
);

   localparam int AW = $clog2(MAX_TABLES * MAX_ENTRIES);
   localparam int IW = $clog2(MAX_ENTRIES);
   localparam int CW = $clog2(MAX_ENTRIES + 1);
   localparam int TW = (MAX_TABLES > 1) ? $clog2(MAX_TABLES) : 1;

   typedef enum logic [7:0] {
      ST_IDLE     = 8'b0000_0001,
      ST_DISP     = 8'b0000_0010,
      ST_RD_FIRST = 8'b0000_0100,
      ST_RD_LAST  = 8'b0000_1000,
      ST_SCAN     = 8'b0001_0000,
      ST_MUL      = 8'b0010_0000,
      ST_DIV      = 8'b0100_0000,
      ST_OUT      = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;

   logic [1:0]              active_ff;
   logic [CW-1:0]           count_ff [MAX_TABLES];
   logic [CW-1:0]           count_in [MAX_TABLES];

   logic [1:0]              act_ff, act_in;
   logic signed [DENS_W-1:0] dens_ff, dens_in;
   logic [LAC_W-1:0]        lacv_ff, lacv_in;
   logic [TW-1:0]           sel_ff, sel_in;
   logic                    tbl_ok_ff, tbl_ok_in;
   logic [AW-1:0]           base_ff, base_in;
   logic [CW-1:0]           n_ff, n_in;
   logic [IW-1:0]           idx_ff, idx_in;
   logic signed [DENS_W-1:0] first_d_ff, first_d_in;
   logic signed [DENS_W-1:0] x_ff, x_in;
   logic signed [DENS_W-1:0] prev_d_ff, prev_d_in;
   logic [LAC_W-1:0]        prev_l_ff, prev_l_in;
   logic [DENS_W-1:0]       dd_ff, dd_in;
   logic [DENS_W-1:0]       den_ff, den_in;
   logic [LAC_W-1:0]        diff_ff, diff_in;
   logic                    neg_ff, neg_in;
   logic [LAC_W-1:0]        l0_ff, l0_in;
   logic [PROD_W-1:0]       prod_ff, prod_in;
   logic                    div_start_ff, div_start_in;
   logic [LAC_W-1:0]        res_lac_ff, res_lac_in;
   logic [1:0]              res_stat_ff, res_stat_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [LAC_W-1:0]        rsp_data_ff, rsp_data_in;
   logic [1:0]              rsp_user_ff, rsp_user_in;

   logic                    req_fire;
   logic [1:0]              tsel;
   logic [TW+1:0]           t_ext;
   logic [CW-1:0]           cnt_cur;
   logic                    ram_we;
   logic [AW-1:0]           ram_waddr;
   logic [AW-1:0]           ram_raddr;
   logic [ENT_W-1:0]        ram_rdata;
   logic signed [DENS_W-1:0] rd_d;
   logic [LAC_W-1:0]        rd_l;
   logic signed [DENS_W-1:0] x_lo;
   logic signed [DENS_W:0]  dd_wide;
   logic signed [DENS_W:0]  den_wide;
   div_ctl_type             div_ctl;
   div_stat_type            div_stat;
   logic [LAC_W-1:0]        div_quot;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign cnt_cur    = count_ff[sel_ff];
   assign rd_d       = signed'(ram_rdata[DENS_W-1:0]);
   assign rd_l       = ram_rdata[ENT_W-1:DENS_W];
   assign div_ctl.start = div_start_ff;

   plti_ram #(
      .WIDTH(ENT_W),
      .DEPTH(MAX_TABLES * MAX_ENTRIES)
   ) u_bp_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data ({lacv_ff, dens_ff}),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   plti_div u_div (
      .clock    (clock),
      .reset    (reset),
      .div_ctl  (div_ctl),
      .numer    (prod_ff),
      .denom    (den_ff),
      .div_stat (div_stat),
      .quot     (div_quot)
   );

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      act_in       = act_ff;
      dens_in      = dens_ff;
      lacv_in      = lacv_ff;
      sel_in       = sel_ff;
      tbl_ok_in    = tbl_ok_ff;
      base_in      = base_ff;
      n_in         = n_ff;
      idx_in       = idx_ff;
      first_d_in   = first_d_ff;
      x_in         = x_ff;
      prev_d_in    = prev_d_ff;
      prev_l_in    = prev_l_ff;
      dd_in        = dd_ff;
      den_in       = den_ff;
      diff_in      = diff_ff;
      neg_in       = neg_ff;
      l0_in        = l0_ff;
      prod_in      = prod_ff;
      div_start_in = (state_ff == ST_MUL);
      res_lac_in   = res_lac_ff;
      res_stat_in  = res_stat_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      ram_we       = 1'b0;
      ram_waddr    = base_ff + AW'(cnt_cur);
      ram_raddr    = base_ff;
      tsel         = (req_tuser[1:0] == ACT_LOOKUP) ? active_ff : req_tuser[3:2];
      t_ext        = (TW + 2)'(tsel);
      x_lo         = (dens_ff < first_d_ff) ? first_d_ff : dens_ff;
      dd_wide      = {x_ff[DENS_W-1], x_ff} - {prev_d_ff[DENS_W-1], prev_d_ff};
      den_wide     = {rd_d[DENS_W-1], rd_d} - {prev_d_ff[DENS_W-1], prev_d_ff};

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               act_in    = req_tuser[1:0];
               dens_in   = signed'(req_tdata[DENS_W-1:0]);
               lacv_in   = req_tdata[ENT_W-1:DENS_W];
               tbl_ok_in = (t_ext < (TW + 2)'(MAX_TABLES));
               sel_in    = tbl_ok_in ? t_ext[TW-1:0] : '0;
               base_in   = AW'(sel_in) * AW'(MAX_ENTRIES);
               state_in  = ST_DISP;
            end
         end
         ST_DISP: begin
            res_lac_in  = '0;
            res_stat_in = STAT_OK;
            n_in        = cnt_cur;
            state_in    = ST_OUT;
            unique case (act_ff)
               ACT_LOOKUP: begin
                  if (!tbl_ok_ff || cnt_cur == '0) begin
                     res_stat_in = STAT_EMPTY;
                  end else begin
                     state_in = ST_RD_FIRST;
                  end
               end
               ACT_APPEND: begin
                  if (!tbl_ok_ff || cnt_cur >= CW'(MAX_ENTRIES)) begin
                     res_stat_in = STAT_FULL;
                  end else begin
                     ram_we           = 1'b1;
                     count_in[sel_ff] = cnt_cur + CW'(1);
                  end
               end
               ACT_CLEAR: begin
                  if (tbl_ok_ff) begin
                     count_in[sel_ff] = '0;
                  end
               end
               default: begin
               end
            endcase
         end
         ST_RD_FIRST: begin
            first_d_in = rd_d;
            ram_raddr  = base_ff + AW'(n_ff - CW'(1));
            state_in   = ST_RD_LAST;
         end
         ST_RD_LAST: begin
            x_in     = (x_lo > rd_d) ? rd_d : x_lo;
            idx_in   = '0;
            state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (rd_d > x_ff) begin
               if (idx_ff == '0) begin
                  res_lac_in = rd_l;
                  state_in   = ST_OUT;
               end else begin
                  dd_in  = dd_wide[DENS_W-1:0];
                  den_in = den_wide[DENS_W-1:0];
                  l0_in  = prev_l_ff;
                  if (rd_l >= prev_l_ff) begin
                     neg_in  = 1'b0;
                     diff_in = rd_l - prev_l_ff;
                  end else begin
                     neg_in  = 1'b1;
                     diff_in = prev_l_ff - rd_l;
                  end
                  state_in = ST_MUL;
               end
            end else begin
               prev_d_in = rd_d;
               prev_l_in = rd_l;
               if (CW'(idx_ff) + CW'(1) == n_ff) begin
                  res_lac_in = rd_l;
                  state_in   = ST_OUT;
               end else begin
                  idx_in    = idx_ff + IW'(1);
                  ram_raddr = base_ff + AW'(idx_in);
               end
            end
         end
         ST_MUL: begin
            prod_in  = PROD_W'(dd_ff) * PROD_W'(diff_ff);
            state_in = ST_DIV;
         end
         ST_DIV: begin
            if (div_stat.done) begin
               res_lac_in = neg_ff ? (l0_ff - div_quot) : (l0_ff + div_quot);
               state_in   = ST_OUT;
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_lac_ff;
               rsp_user_in  = res_stat_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      act_ff      <= act_in;
      dens_ff     <= dens_in;
      lacv_ff     <= lacv_in;
      tbl_ok_ff   <= tbl_ok_in;
      base_ff     <= base_in;
      n_ff        <= n_in;
      idx_ff      <= idx_in;
      first_d_ff  <= first_d_in;
      x_ff        <= x_in;
      prev_d_ff   <= prev_d_in;
      prev_l_ff   <= prev_l_in;
      dd_ff       <= dd_in;
      den_ff      <= den_in;
      diff_ff     <= diff_in;
      neg_ff      <= neg_in;
      l0_ff       <= l0_in;
      prod_ff     <= prod_in;
      res_lac_ff  <= res_lac_in;
      res_stat_ff <= res_stat_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         active_ff    <= '0;
         sel_ff       <= '0;
         div_start_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < MAX_TABLES; i++) begin
            count_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         sel_ff       <= sel_in;
         div_start_ff <= div_start_in;
         rsp_valid_ff <= rsp_valid_in;
         count_ff     <= count_in;
         if (csr_wr_en) begin
            active_ff <= csr_wr_data;
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   `PLTI_ASSERT_NXT(a_busy_after_accept, clock, reset, req_fire, !req_tready, "accepted while busy")
   `PLTI_ASSERT_IMP(a_err_zero, clock, reset, rsp_tvalid && rsp_tuser != STAT_OK, rsp_tdata == '0, "error result carries nonzero lac")
   `PLTI_ASSERT_IMP(a_div_done_state, clock, reset, div_stat.done, state_ff == ST_DIV, "divider finished outside the divide state")
   `PLTI_ASSERT_IMP(a_count_bound, clock, reset, 1'b1, cnt_cur <= CW'(MAX_ENTRIES), "table entry count out of range")

endmodule
`default_nettype wire

/* design/plti_ram.sv */
// Generic simple dual-port RAM with a registered read port.
`timescale 1ns / 1ps
`default_nettype none
module plti_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

/* design/plti_div.sv */
// Bit-serial divider that forms one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module plti_div
   import plti_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire div_ctl_type       div_ctl,
   input  wire logic [PROD_W-1:0] numer,
   input  wire logic [DENS_W-1:0] denom,
   output div_stat_type           div_stat,
   output logic      [LAC_W-1:0]  quot
);

   logic [DENS_W-1:0] rem_ff, rem_in;
   logic [LAC_W-1:0]  quo_ff, quo_in;
   logic [DENS_W-1:0] den_ff, den_in;
   logic [DCNT_W-1:0] cnt_ff, cnt_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [DENS_W:0]   shifted;
   logic [DENS_W+1:0] trial;
   logic              borrow;

   always_comb begin
      shifted = {rem_ff, quo_ff[LAC_W-1]};
      trial   = {1'b0, shifted} - {2'b00, den_ff};
      borrow  = trial[DENS_W+1];
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (div_ctl.start) begin
         rem_in  = numer[PROD_W-1:LAC_W];
         quo_in  = numer[LAC_W-1:0];
         den_in  = denom;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = borrow ? shifted[DENS_W-1:0] : trial[DENS_W-1:0];
         quo_in = {quo_ff[LAC_W-2:0], ~borrow};
         cnt_in = cnt_ff + DCNT_W'(1);
         if (cnt_ff == DCNT_W'(LAC_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign div_stat.busy = busy_ff;
   assign div_stat.done = done_ff;
   assign quot          = quo_ff;

endmodule
`default_nettype wire

/* test/testbench.sv */
// Self-checking testbench for the piecewise linear attenuation table interpolator.
`timescale 1ns / 1ps
`default_nettype none
module testbench
   import plti_pkg::*;
;

   localparam int NUM_TABLES = 4;
   localparam int TABLE_DEPTH = 64;
   localparam int ITEM_TARGET = 1470;
   localparam int CALM_AFTER = 1350;
   localparam int QUIET_CYCLES = 8;
   localparam int SETTLE_CYCLES = 150;
   localparam logic [1:0] ACT_UNUSED = 2'd3;

   typedef struct packed {
      logic [31:0] lac;
      logic [1:0]  status;
   } attenuation_result_type;

   logic        clock;
   logic        reset;
   logic        csr_wr_en;
   logic [1:0]  csr_wr_data;
   logic        req_tvalid;
   logic        req_tready;
   logic [47:0] req_tdata;  // density[15:0], lac_value[47:16]
   logic [3:0]  req_tuser;  // action[1:0], table_id[3:2]
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [31:0] rsp_tdata;  // lac[31:0]
   logic [1:0]  rsp_tuser;  // status[1:0]

   logic signed [15:0] tbl_density [NUM_TABLES][TABLE_DEPTH];
   logic [31:0]        tbl_lac [NUM_TABLES][TABLE_DEPTH];
   int                 tbl_count [NUM_TABLES];
   logic [1:0]         active_tbl;

   attenuation_result_type pending_attenuation[$];
   int  items_sent;
   int  mismatch_count;
   bit  idle_on;

   piecewise_linear_table_interp_top #(
      .MAX_TABLES(NUM_TABLES),
      .MAX_ENTRIES(TABLE_DEPTH)
   ) dut (
      .clock(clock),
      .reset(reset),
      .csr_wr_en(csr_wr_en),
      .csr_wr_data(csr_wr_data),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #10_000_000;
      $display("testbench: FAIL");
      $finish;
   end

   function automatic attenuation_result_type compute_attenuation(
         input logic signed [15:0] dens);
      attenuation_result_type r;
      int n, found, i, first, last, x, d0, d1;
      logic [31:0] l0, l1;
      logic [63:0] dd, den, diff, q;
      r.lac = '0;
      r.status = STAT_OK;
      n = tbl_count[active_tbl];
      if (n == 0) begin
         r.status = STAT_EMPTY;
         return r;
      end
      first = tbl_density[active_tbl][0];
      last = tbl_density[active_tbl][n - 1];
      x = dens;
      if (x < first) x = first;
      if (x > last) x = last;
      found = n;
      for (i = 0; i < n; i++) begin
         if (int'(tbl_density[active_tbl][i]) > x) begin
            found = i;
            break;
         end
      end
      if (found == n) begin
         r.lac = tbl_lac[active_tbl][n - 1];
      end else if (found == 0) begin
         r.lac = tbl_lac[active_tbl][0];
      end else begin
         d0 = tbl_density[active_tbl][found - 1];
         d1 = tbl_density[active_tbl][found];
         l0 = tbl_lac[active_tbl][found - 1];
         l1 = tbl_lac[active_tbl][found];
         dd = 64'(x - d0);
         den = 64'(d1 - d0);
         diff = (l1 >= l0) ? 64'(l1 - l0) : 64'(l0 - l1);
         q = (dd * diff) / den;
         r.lac = (l1 >= l0) ? l0 + q[31:0] : l0 - q[31:0];
      end
      return r;
   endfunction

   function automatic attenuation_result_type apply_table_action(input logic [1:0] action,
         input logic [1:0] tid, input logic signed [15:0] dens, input logic [31:0] lacv);
      attenuation_result_type r;
      r.lac = '0;
      r.status = STAT_OK;
      case (action)
         ACT_LOOKUP: begin
            r = compute_attenuation(dens);
         end
         ACT_APPEND: begin
            if (tbl_count[tid] >= TABLE_DEPTH) begin
               r.status = STAT_FULL;
            end else begin
               tbl_density[tid][tbl_count[tid]] = dens;
               tbl_lac[tid][tbl_count[tid]] = lacv;
               tbl_count[tid]++;
            end
         end
         ACT_CLEAR: begin
            tbl_count[tid] = 0;
         end
         default: begin
         end
      endcase
      return r;
   endfunction

   task automatic send_item(input logic [1:0] action, input logic [1:0] tid,
         input logic [15:0] dens, input logic [31:0] lacv);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 15)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {lacv, dens};
      req_tuser <= {tid, action};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pending_attenuation = {pending_attenuation, apply_table_action(action, tid, dens, lacv)};
      items_sent++;
      if (items_sent >= CALM_AFTER) idle_on = 1'b0;
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_attenuation.size() != 0) @(posedge clock);
      repeat (QUIET_CYCLES) @(posedge clock);
   endtask

   task automatic set_active_table(input logic [1:0] tbl);
      wait_idle();
      csr_wr_en <= 1'b1;
      csr_wr_data <= tbl;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      active_tbl = tbl;
   endtask

   task automatic send_noise();
      if ($urandom_range(0, 9) == 0) begin
         send_item(2'($urandom_range(0, 3)), 2'($urandom), 16'($urandom), $urandom);
      end
   endtask

   function automatic logic [15:0] pick_density();
      int n, first, last;
      n = tbl_count[active_tbl];
      if (n == 0) return 16'($urandom);
      first = tbl_density[active_tbl][0];
      last = tbl_density[active_tbl][n - 1];
      case ($urandom_range(0, 7))
         0: return 16'h8000;
         1: return 16'h7fff;
         2, 3: return tbl_density[active_tbl][$urandom_range(0, n - 1)];
         4: return tbl_density[active_tbl][$urandom_range(0, n - 1)]
               + 16'($urandom_range(0, 2) - 1);
         5: return 16'($urandom);
         default: begin
            if (last >= first) return 16'(first + int'($urandom_range(0, last - first)));
            return 16'($urandom);
         end
      endcase
   endfunction

   task automatic test_empty_lookup();
      send_item(ACT_LOOKUP, 2'd0, 16'h8000, 32'hffff_ffff);
      send_item(ACT_LOOKUP, 2'd3, 16'h7fff, 32'h0000_0000);
   endtask

   task automatic test_single_breakpoint();
      send_item(ACT_APPEND, 2'd0, 16'h8000, 32'hffff_ffff);
      send_item(ACT_LOOKUP, 2'd0, 16'h7fff, 32'h0);
      send_item(ACT_LOOKUP, 2'd0, 16'h8000, 32'h0);
   endtask

   task automatic test_interpolation();
      send_item(ACT_APPEND, 2'd0, 16'h7fff, 32'h0000_0000);
      send_item(ACT_LOOKUP, 2'd0, 16'h8000, 32'h0);
      send_item(ACT_LOOKUP, 2'd0, 16'h0000, 32'h0);
      send_item(ACT_LOOKUP, 2'd0, 16'h7fff, 32'h0);
      send_item(ACT_CLEAR, 2'd1, 16'h0, 32'h0);
      send_item(ACT_APPEND, 2'd1, -16'sd100, 32'h0000_0000);
      send_item(ACT_APPEND, 2'd1, 16'sd100, 32'hffff_ffff);
      set_active_table(2'd1);
      send_item(ACT_LOOKUP, 2'd0, -16'sd200, 32'h0);
      send_item(ACT_LOOKUP, 2'd0, 16'sd0, 32'h0);
      send_item(ACT_LOOKUP, 2'd0, 16'sd99, 32'h0);
      send_item(ACT_LOOKUP, 2'd0, 16'sd100, 32'h0);
   endtask

   task automatic test_out_of_order();
      send_item(ACT_APPEND, 2'd2, 16'sd50, 32'h0001_0000);
      send_item(ACT_APPEND, 2'd2, 16'sd10, 32'h0003_0000);
      send_item(ACT_APPEND, 2'd2, 16'sd30, 32'h0002_0000);
      set_active_table(2'd2);
      send_item(ACT_LOOKUP, 2'd0, 16'sd0, 32'h0);
      send_item(ACT_LOOKUP, 2'd0, 16'sd40, 32'h0);
   endtask

   task automatic test_unused_and_clear();
      send_item(ACT_UNUSED, 2'd3, 16'hffff, 32'hffff_ffff);
      send_item(ACT_CLEAR, 2'd2, 16'hffff, 32'hffff_ffff);
      send_item(ACT_LOOKUP, 2'd2, 16'h0, 32'h0);
   endtask

   task automatic test_table_capacity();
      int i, cur;
      cur = -32768;
      send_item(ACT_CLEAR, 2'd3, 16'($urandom), $urandom);
      for (i = 0; i < TABLE_DEPTH; i++) begin
         send_item(ACT_APPEND, 2'd3, 16'(cur), $urandom);
         cur = cur + int'($urandom_range(0, 1023));
      end
      send_item(ACT_APPEND, 2'd3, 16'($urandom), $urandom);
      send_item(ACT_APPEND, 2'd3, 16'($urandom), $urandom);
      set_active_table(2'd3);
      for (i = 0; i < 12; i++) begin
         send_item(ACT_LOOKUP, 2'($urandom), pick_density(), $urandom);
      end
      send_item(ACT_CLEAR, 2'd3, 16'($urandom), $urandom);
      send_item(ACT_LOOKUP, 2'($urandom), 16'($urandom), $urandom);
   endtask

   task automatic run_table_phase();
      int tbl, n, lo, span, cur, k, i;
      bit ordered;
      tbl = $urandom_range(0, NUM_TABLES - 1);
      n = ($urandom_range(0, 7) == 0) ? $urandom_range(9, TABLE_DEPTH) : $urandom_range(1, 8);
      ordered = ($urandom_range(0, 9) != 0);
      lo = ($urandom_range(0, 3) == 0) ? -32768 : -32768 + int'($urandom_range(0, 60000));
      span = 32767 - lo;
      cur = lo;
      send_item(ACT_CLEAR, 2'(tbl), 16'($urandom), $urandom);
      for (i = 0; i < n; i++) begin
         send_noise();
         send_item(ACT_APPEND, 2'(tbl), ordered ? 16'(cur) : 16'($urandom), $urandom);
         cur = cur + int'($urandom_range(0, span / n));
      end
      set_active_table(($urandom_range(0, 4) == 0) ? 2'($urandom) : 2'(tbl));
      k = $urandom_range(4, 16);
      for (i = 0; i < k; i++) begin
         send_noise();
         send_item(ACT_LOOKUP, 2'($urandom), pick_density(), $urandom);
      end
   endtask

   task automatic test_random_tables();
      while (items_sent < ITEM_TARGET) run_table_phase();
   endtask

   initial begin
      rsp_tready = 1'b0;
      repeat (3) @(posedge clock);
      forever begin
         rsp_tready <= 1'b1;
         repeat ($urandom_range(1, 40)) @(posedge clock);
         if (idle_on && $urandom_range(0, 1) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clock);
         end
      end
   end

   always @(posedge clock) begin
      attenuation_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_attenuation.size() == 0) begin
            if (mismatch_count < 10)
               $display("%0t: unexpected result lac=%h status=%0d", $realtime, rsp_tdata,
                  rsp_tuser);
            mismatch_count++;
         end else begin
            want = pending_attenuation.pop_front();
            if (want.lac !== rsp_tdata || want.status !== rsp_tuser) begin
               if (mismatch_count < 10)
                  $display("%0t: mismatch lac expected %h actual %h, %s %0d actual %0d",
                     $realtime, want.lac, rsp_tdata, "status expected", want.status,
                     rsp_tuser);
               mismatch_count++;
            end
         end
      end
   end

   initial begin
      reset = 1'b1;
      csr_wr_en = 1'b0;
      csr_wr_data = '0;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = '0;
      idle_on = 1'b1;
      items_sent = 0;
      mismatch_count = 0;
      active_tbl = '0;
      foreach (tbl_count[i]) tbl_count[i] = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_empty_lookup();
      test_single_breakpoint();
      test_interpolation();
      test_out_of_order();
      test_unused_and_clear();
      set_active_table(2'd0);
      test_table_capacity();
      test_random_tables();
      set_active_table(2'd3);
      test_table_capacity();
      wait_idle();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && pending_attenuation.size() == 0)
         $display("testbench: PASS");
      else
         $display("testbench: FAIL");
      $finish;
   end

endmodule
`default_nettype wire
